// ===== rtl/core/cbm_pkg.sv =====
// Shared types and constants for the cartridge bank mapper with scanline interrupt.
package cbm_pkg;

   localparam int CPU_ADDR_W  = 16;
   localparam int PPU_ADDR_W  = 14;
   localparam int DATA_W      = 8;
   localparam int PRG_BANK_W  = 6;
   localparam int CHR_BANK_W  = 8;
   localparam int BANK_CNT_W  = 7;
   localparam int IRQ_COUNT_W = 10;
   localparam int NUM_BANKS   = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam int EDGE_FILTER_TICKS_DEFAULT = 9;

   localparam logic [BANK_CNT_W-1:0] PRG_BANK_COUNT_RESET = 7'd64;

   // Item kinds
   localparam logic REQ_CPU_WRITE  = 1'b0;
   localparam logic REQ_VIDEO_TICK = 1'b1;

   // Configuration register indexes (paddr[2])
   localparam logic CSR_PRG_BANK_COUNT = 1'b0;
   localparam logic CSR_FOUR_SCREEN    = 1'b1;

   // Write regions of the upper half of the CPU map (address bits 14:13)
   localparam logic [1:0] REGION_BANK = 2'd0;
   localparam logic [1:0] REGION_MIRR = 2'd1;
   localparam logic [1:0] REGION_IRQ  = 2'd2;
   localparam logic [1:0] REGION_ENAB = 2'd3;

   // Work RAM window 0x6000-0x7FFF on address bits 15:13
   localparam logic [2:0] WRAM_WINDOW = 3'b011;

   localparam int FIXED_BANK_R6 = 6;
   localparam int FIXED_BANK_R7 = 7;

   typedef struct packed {
      logic                  req_type;
      logic [CPU_ADDR_W-1:0] cpu_addr;
      logic [DATA_W-1:0]     cpu_data;
      logic [PPU_ADDR_W-1:0] ppu_addr;
   } req_item_type;

   typedef struct packed {
      logic                  irq_request;
      logic                  mirror_horizontal;
      logic                  ram_write_blocked;
      logic                  ram_enabled;
      logic [PRG_BANK_W-1:0] prg_bank;
      logic [CHR_BANK_W-1:0] chr_bank;
   } rsp_item_type;

   typedef struct packed {
      logic                               prg_mode;
      logic                               chr_invert;
      logic                               mirror_flag;
      logic                               write_protect;
      logic                               ram_enable;
      logic [NUM_BANKS-1:0][DATA_W-1:0]   bank_regs;
   } map_state_type;

   typedef struct packed {
      logic              tick;
      logic              a12;
      logic              count_reload;
      logic              irq_on;
      logic [DATA_W-1:0] irq_latch;
   } irq_ctrl_type;

endpackage

// ===== rtl/core/cartridge_bank_mapper_irq_core.sv =====
// An accepted request is held in the input register, its response in the result
// register on rsp_valid. Throughput: one transaction per cycle unless rsp_stall holds;
// each has one item, and a single pass of decode, counter and translation sits between.
// Reset (synchronous, active high) clears every mapper register, the counter and the
// edge filter, empties both stages and sets prg_bank_count to 64, four_screen to 0.
// Top level of the cartridge bank mapper with scanline interrupt counter.
module cartridge_bank_mapper_irq_core #(
   parameter int EDGE_FILTER_TICKS = cbm_pkg::EDGE_FILTER_TICKS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  cbm_pkg::req_item_type          req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output cbm_pkg::rsp_item_type          rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [cbm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [cbm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [cbm_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import cbm_pkg::*;

   logic [BANK_CNT_W-1:0] prg_bank_count_ff, prg_bank_count_in;
   logic                  four_screen_ff, four_screen_in;
   logic                  s1_valid_ff, s1_valid_in;
   req_item_type          s1_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_data_ff, rsp_data_in;
   logic                  accept;
   logic                  fire;
   logic                  csr_write;
   logic                  is_write;
   logic                  is_tick;
   map_state_type         state_next;
   irq_ctrl_type          irq_ctrl;
   logic                  irq_request;
   logic [PRG_BANK_W-1:0] prg_bank;
   logic [CHR_BANK_W-1:0] chr_bank;

   // Configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      prg_bank_count_in = prg_bank_count_ff;
      four_screen_in    = four_screen_ff;
      if (csr_write) begin
         case (paddr[2])
            CSR_PRG_BANK_COUNT: prg_bank_count_in = pwdata[BANK_CNT_W-1:0];
            CSR_FOUR_SCREEN:    four_screen_in    = pwdata[0];
            default:            four_screen_in    = four_screen_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_PRG_BANK_COUNT: prdata = {{(CSR_DATA_W-BANK_CNT_W){1'b0}}, prg_bank_count_ff};
         CSR_FOUR_SCREEN:    prdata = {{(CSR_DATA_W-1){1'b0}}, four_screen_ff};
         default:            prdata = '0;
      endcase
   end

   // Advance the input stage whenever the result register is free or being drained
   assign fire      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   assign is_write = fire && (s1_data_ff.req_type == REQ_CPU_WRITE);
   assign is_tick  = fire && (s1_data_ff.req_type == REQ_VIDEO_TICK);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   cbm_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .write_en    (is_write),
      .cpu_addr    (s1_data_ff.cpu_addr),
      .cpu_data    (s1_data_ff.cpu_data),
      .four_screen (four_screen_ff),
      .tick_en     (is_tick),
      .ppu_addr    (s1_data_ff.ppu_addr),
      .state_next  (state_next),
      .irq_ctrl    (irq_ctrl)
   );

   cbm_irq #(
      .EDGE_FILTER_TICKS (EDGE_FILTER_TICKS)
   ) u_irq (
      .clock       (clock),
      .reset       (reset),
      .enable      (fire),
      .ctrl        (irq_ctrl),
      .irq_request (irq_request)
   );

   cbm_xlate u_xlate (
      .state          (state_next),
      .prg_bank_count (prg_bank_count_ff),
      .cpu_addr       (s1_data_ff.cpu_addr),
      .ppu_addr       (s1_data_ff.ppu_addr),
      .prg_bank       (prg_bank),
      .chr_bank       (chr_bank)
   );

   always_comb begin
      rsp_data_in.irq_request       = irq_request;
      rsp_data_in.mirror_horizontal = state_next.mirror_flag;
      rsp_data_in.ram_write_blocked = (s1_data_ff.req_type == REQ_CPU_WRITE)
                                      && state_next.write_protect
                                      && (s1_data_ff.cpu_addr[CPU_ADDR_W-1:CPU_ADDR_W-3]
                                          == WRAM_WINDOW);
      rsp_data_in.ram_enabled       = state_next.ram_enable;
      rsp_data_in.prg_bank          = prg_bank;
      rsp_data_in.chr_bank          = chr_bank;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_bank_count_ff <= PRG_BANK_COUNT_RESET;
         four_screen_ff    <= 1'b0;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         prg_bank_count_ff <= prg_bank_count_in;
         four_screen_ff    <= four_screen_in;
         s1_valid_ff       <= s1_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset) $rose(rsp_valid_ff) |-> $past(fire))
      else $error("response raised without a processed transaction");

   assert property (@(posedge clock) disable iff (reset) fire |=> rsp_valid_ff)
      else $error("processed transaction lost before the result register");

   assert property (@(posedge clock) disable iff (reset) !s1_valid_ff |-> !req_stall)
      else $error("request stalled while the input stage is empty");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && !fire) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("held response changed while stalled");

endmodule

// ===== rtl/core/cbm_regs.sv =====
// CPU write decoder and the mapper's bank, mode and interrupt control registers.
module cbm_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           write_en,
   input  logic [cbm_pkg::CPU_ADDR_W-1:0] cpu_addr,
   input  logic [cbm_pkg::DATA_W-1:0]     cpu_data,
   input  logic                           four_screen,
   input  logic                           tick_en,
   input  logic [cbm_pkg::PPU_ADDR_W-1:0] ppu_addr,
   output cbm_pkg::map_state_type         state_next,
   output cbm_pkg::irq_ctrl_type          irq_ctrl
);
   import cbm_pkg::*;

   logic [2:0]                     bank_select_ff, bank_select_in;
   logic                           prg_mode_ff, prg_mode_in;
   logic                           chr_invert_ff, chr_invert_in;
   logic [NUM_BANKS-1:0][DATA_W-1:0] bank_regs_ff, bank_regs_in;
   logic                           mirror_flag_ff, mirror_flag_in;
   logic                           write_protect_ff, write_protect_in;
   logic                           ram_enable_ff, ram_enable_in;
   logic [DATA_W-1:0]              irq_latch_ff, irq_latch_in;
   logic                           irq_on_ff, irq_on_in;
   logic                           odd;
   logic                           hit;
   logic [1:0]                     region;

   assign odd    = cpu_addr[0];
   assign hit    = write_en && cpu_addr[CPU_ADDR_W-1];
   assign region = cpu_addr[CPU_ADDR_W-2:CPU_ADDR_W-3];

   always_comb begin
      bank_select_in   = bank_select_ff;
      prg_mode_in      = prg_mode_ff;
      chr_invert_in    = chr_invert_ff;
      bank_regs_in     = bank_regs_ff;
      mirror_flag_in   = mirror_flag_ff;
      write_protect_in = write_protect_ff;
      ram_enable_in    = ram_enable_ff;
      irq_latch_in     = irq_latch_ff;
      irq_on_in        = irq_on_ff;
      if (hit) begin
         case (region)
            REGION_BANK: begin
               if (!odd) begin
                  bank_select_in = cpu_data[2:0];
                  prg_mode_in    = cpu_data[6];
                  chr_invert_in  = cpu_data[7];
               end else begin
                  bank_regs_in[bank_select_ff] = cpu_data;
               end
            end
            REGION_MIRR: begin
               if (!odd) begin
                  if (!four_screen) begin
                     mirror_flag_in = cpu_data[0];
                  end
               end else begin
                  write_protect_in = cpu_data[6];
                  ram_enable_in    = cpu_data[7];
               end
            end
            REGION_IRQ: begin
               if (!odd) begin
                  irq_latch_in = cpu_data;
               end
            end
            REGION_ENAB: begin
               irq_on_in = odd;
            end
            default: begin
               irq_on_in = irq_on_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_select_ff   <= '0;
         prg_mode_ff      <= 1'b0;
         chr_invert_ff    <= 1'b0;
         bank_regs_ff     <= '0;
         mirror_flag_ff   <= 1'b0;
         write_protect_ff <= 1'b0;
         ram_enable_ff    <= 1'b0;
         irq_latch_ff     <= '0;
         irq_on_ff        <= 1'b0;
      end else begin
         bank_select_ff   <= bank_select_in;
         prg_mode_ff      <= prg_mode_in;
         chr_invert_ff    <= chr_invert_in;
         bank_regs_ff     <= bank_regs_in;
         mirror_flag_ff   <= mirror_flag_in;
         write_protect_ff <= write_protect_in;
         ram_enable_ff    <= ram_enable_in;
         irq_latch_ff     <= irq_latch_in;
         irq_on_ff        <= irq_on_in;
      end
   end

   // Translation sees the state as left by this transaction
   always_comb begin
      state_next.prg_mode      = prg_mode_in;
      state_next.chr_invert    = chr_invert_in;
      state_next.mirror_flag   = mirror_flag_in;
      state_next.write_protect = write_protect_in;
      state_next.ram_enable    = ram_enable_in;
      state_next.bank_regs     = bank_regs_in;
   end

   always_comb begin
      irq_ctrl.tick         = tick_en;
      irq_ctrl.a12          = ppu_addr[12];
      irq_ctrl.count_reload = hit && (region == REGION_IRQ) && odd;
      irq_ctrl.irq_on       = irq_on_ff;
      irq_ctrl.irq_latch    = irq_latch_ff;
   end

endmodule

// ===== rtl/core/cbm_irq.sv =====
// Rising-edge filter on the a12 address line and scanline interrupt counter.
module cbm_irq #(
   parameter int EDGE_FILTER_TICKS = cbm_pkg::EDGE_FILTER_TICKS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  cbm_pkg::irq_ctrl_type ctrl,
   output logic                  irq_request
);
   import cbm_pkg::*;

   localparam int LOW_W = $clog2(EDGE_FILTER_TICKS + 1);
   localparam logic [LOW_W-1:0] LOW_MAX = LOW_W'(EDGE_FILTER_TICKS);
   localparam logic signed [IRQ_COUNT_W-1:0] COUNT_RELOAD = '1;

   logic signed [IRQ_COUNT_W-1:0] irq_count_ff, irq_count_in;
   logic signed [IRQ_COUNT_W-1:0] count_dec;
   logic [LOW_W-1:0]              low_ticks_ff, low_ticks_in;
   logic                          last_a12_ff, last_a12_in;
   logic                          rise;
   logic                          count_clock;

   assign rise        = ctrl.tick && ctrl.a12 && !last_a12_ff;
   assign count_clock = rise && (low_ticks_ff >= LOW_MAX);
   assign count_dec   = irq_count_ff - IRQ_COUNT_W'(1);
   assign irq_request = count_clock && (count_dec == '0) && ctrl.irq_on;

   always_comb begin
      irq_count_in = irq_count_ff;
      low_ticks_in = low_ticks_ff;
      last_a12_in  = last_a12_ff;
      if (ctrl.count_reload) begin
         irq_count_in = COUNT_RELOAD;
      end else if (count_clock) begin
         if (count_dec <= $signed(IRQ_COUNT_W'(0))) begin
            irq_count_in = $signed({{(IRQ_COUNT_W-DATA_W){1'b0}}, ctrl.irq_latch});
         end else begin
            irq_count_in = count_dec;
         end
      end
      if (ctrl.tick) begin
         last_a12_in = ctrl.a12;
         if (rise) begin
            low_ticks_in = '0;
         end else if (!ctrl.a12 && (low_ticks_ff < LOW_MAX)) begin
            low_ticks_in = low_ticks_ff + LOW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_count_ff <= '0;
         low_ticks_ff <= '0;
         last_a12_ff  <= 1'b0;
      end else if (enable) begin
         irq_count_ff <= irq_count_in;
         low_ticks_ff <= low_ticks_in;
         last_a12_ff  <= last_a12_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) low_ticks_ff <= LOW_MAX)
      else $error("low tick count beyond filter length");

endmodule

// ===== rtl/core/cbm_xlate.sv =====
// Program and character bank translation from the mapper state.
module cbm_xlate (
   input  cbm_pkg::map_state_type           state,
   input  logic [cbm_pkg::BANK_CNT_W-1:0]   prg_bank_count,
   input  logic [cbm_pkg::CPU_ADDR_W-1:0]   cpu_addr,
   input  logic [cbm_pkg::PPU_ADDR_W-1:0]   ppu_addr,
   output logic [cbm_pkg::PRG_BANK_W-1:0]   prg_bank,
   output logic [cbm_pkg::CHR_BANK_W-1:0]   chr_bank
);
   import cbm_pkg::*;

   logic [PRG_BANK_W-1:0] second_last;
   logic [PRG_BANK_W-1:0] last;
   logic [PRG_BANK_W-1:0] r6;
   logic [PRG_BANK_W-1:0] r7;
   logic [2:0]            slot;
   logic [DATA_W-1:0]     pair_reg;

   assign second_last = prg_bank_count[PRG_BANK_W-1:0] - PRG_BANK_W'(2);
   assign last        = prg_bank_count[PRG_BANK_W-1:0] - PRG_BANK_W'(1);
   assign r6          = state.bank_regs[FIXED_BANK_R6][PRG_BANK_W-1:0];
   assign r7          = state.bank_regs[FIXED_BANK_R7][PRG_BANK_W-1:0];

   always_comb begin
      if (!cpu_addr[CPU_ADDR_W-1]) begin
         prg_bank = '0;
      end else begin
         case (cpu_addr[CPU_ADDR_W-2:CPU_ADDR_W-3])
            2'd0:    prg_bank = state.prg_mode ? second_last : r6;
            2'd1:    prg_bank = r7;
            2'd2:    prg_bank = state.prg_mode ? r6 : second_last;
            default: prg_bank = last;
         endcase
      end
   end

   // Invert swaps the 2 KiB and 1 KiB halves of the pattern space
   assign slot     = {ppu_addr[12] ^ state.chr_invert, ppu_addr[11:10]};
   assign pair_reg = state.bank_regs[{2'b00, slot[1]}];

   always_comb begin
      if (ppu_addr[13]) begin
         chr_bank = '0;
      end else if (!slot[2]) begin
         chr_bank = {pair_reg[DATA_W-1:1], slot[0]};
      end else begin
         chr_bank = state.bank_regs[slot - 3'd2];
      end
   end

endmodule

// ===== dv/tb_cartridge_bank_mapper_irq_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the cartridge bank mapper core with scanline interrupt counter.
module tb_cartridge_bank_mapper_irq_core;
   import cbm_pkg::*;

   localparam int FILTER_TICKS = EDGE_FILTER_TICKS_DEFAULT;
   localparam int QUIET_LIMIT  = 4000;
   localparam int SEGMENTS     = 6;
   localparam int SEGMENT_ITEMS = 258;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   always #4 clock = ~clock;

   cartridge_bank_mapper_irq_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // Shadow copy of the mapper registers, counter and edge filter
   logic [BANK_CNT_W-1:0]         m_bank_count;
   logic                          m_four_screen;
   logic [2:0]                    m_bank_sel;
   logic                          m_prg_mode;
   logic                          m_chr_inv;
   logic [DATA_W-1:0]             m_banks [NUM_BANKS];
   logic                          m_mirror;
   logic                          m_wprot;
   logic                          m_ram_en;
   logic [DATA_W-1:0]             m_latch;
   logic signed [IRQ_COUNT_W-1:0] m_count;
   logic                          m_irq_on;
   logic                          m_last_a12;
   logic [3:0]                    m_low_ticks;

   req_item_type pending_txn [$];
   rsp_item_type awaited_rsp [$];
   int  n_queued = 0;
   int  n_checked = 0;
   int  n_errors = 0;
   int  quiet_cycles = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   logic req_taken = 1'b0;

   function automatic rsp_item_type mapper_step(req_item_type it);
      rsp_item_type           r;
      logic                   a12;
      logic [BANK_CNT_W-1:0]  second_last;
      logic [BANK_CNT_W-1:0]  last_bank;
      logic [PPU_ADDR_W-1:0]  va;
      logic [2:0]             slot;
      r = '0;
      if (it.req_type == REQ_CPU_WRITE) begin
         if (it.cpu_addr[15]) begin
            case (it.cpu_addr[14:13])
               REGION_BANK: begin
                  if (!it.cpu_addr[0]) begin
                     m_bank_sel = it.cpu_data[2:0];
                     m_prg_mode = it.cpu_data[6];
                     m_chr_inv  = it.cpu_data[7];
                  end else begin
                     m_banks[m_bank_sel] = it.cpu_data;
                  end
               end
               REGION_MIRR: begin
                  if (!it.cpu_addr[0]) begin
                     if (!m_four_screen) m_mirror = it.cpu_data[0];
                  end else begin
                     m_wprot  = it.cpu_data[6];
                     m_ram_en = it.cpu_data[7];
                  end
               end
               REGION_IRQ: begin
                  if (!it.cpu_addr[0]) m_latch = it.cpu_data;
                  else m_count = -10'sd1;
               end
               default: m_irq_on = it.cpu_addr[0];
            endcase
         end
         r.ram_write_blocked = m_wprot && (it.cpu_addr[15:13] == WRAM_WINDOW);
      end else begin
         a12 = it.ppu_addr[12];
         if (a12 && !m_last_a12) begin
            // clock the counter only after a long enough low stretch
            if (m_low_ticks >= FILTER_TICKS) begin
               m_count = m_count - 10'sd1;
               if (m_count == 0 && m_irq_on) r.irq_request = 1'b1;
               if (m_count <= 0) m_count = {2'b00, m_latch};
            end
            m_low_ticks = '0;
         end
         m_last_a12 = a12;
         if (!a12 && m_low_ticks < FILTER_TICKS) m_low_ticks = m_low_ticks + 4'd1;
      end
      r.mirror_horizontal = m_mirror;
      r.ram_enabled       = m_ram_en;
      second_last = m_bank_count - 7'd2;
      last_bank   = m_bank_count - 7'd1;
      if (it.cpu_addr[15]) begin
         case (it.cpu_addr[14:13])
            REGION_BANK: r.prg_bank = m_prg_mode ? second_last[5:0]
                                                 : m_banks[FIXED_BANK_R6][5:0];
            REGION_MIRR: r.prg_bank = m_banks[FIXED_BANK_R7][5:0];
            REGION_IRQ:  r.prg_bank = m_prg_mode ? m_banks[FIXED_BANK_R6][5:0]
                                                 : second_last[5:0];
            default:     r.prg_bank = last_bank[5:0];
         endcase
      end
      if (!it.ppu_addr[13]) begin
         va   = it.ppu_addr ^ (m_chr_inv ? 14'h1000 : 14'h0000);
         slot = va[12:10];
         // 2 KiB windows pair an even bank with its odd neighbour
         if (!slot[2]) r.chr_bank = {m_banks[slot[1]][7:1], slot[0]};
         else r.chr_bank = m_banks[slot - 3'd2];
      end
      return r;
   endfunction

   function automatic req_item_type make_item(logic kind, logic [CPU_ADDR_W-1:0] ca,
                                              logic [DATA_W-1:0] cd,
                                              logic [PPU_ADDR_W-1:0] pa);
      req_item_type it;
      it.req_type = kind;
      it.cpu_addr = ca;
      it.cpu_data = cd;
      it.ppu_addr = pa;
      return it;
   endfunction

   task automatic queue_item(req_item_type it);
      pending_txn.push_back(it);
      n_queued++;
   endtask

   // Low ticks on line 12, then high ticks; other bits random
   task automatic queue_scanline(int n_low, int n_high);
      logic [PPU_ADDR_W-1:0] pa;
      for (int i = 0; i < n_low + n_high; i++) begin
         pa     = PPU_ADDR_W'($urandom);
         pa[12] = (i >= n_low);
         queue_item(make_item(REQ_VIDEO_TICK, CPU_ADDR_W'($urandom), DATA_W'($urandom), pa));
      end
   endtask

   task automatic queue_random(int n);
      int done;
      int pick;
      int n_low;
      int n_high;
      logic [CPU_ADDR_W-1:0] ca;
      logic [DATA_W-1:0]     cd;
      done = 0;
      while (done < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            n_low  = $urandom_range(0, 14);
            n_high = $urandom_range(1, 4);
            queue_scanline(n_low, n_high);
            done += n_low + n_high;
         end else begin
            ca = CPU_ADDR_W'($urandom);
            cd = DATA_W'($urandom);
            if (pick < 80) ca[15] = 1'b1;
            else if (pick < 90) ca[15:13] = WRAM_WINDOW;
            // keep the latch small most of the time so the counter reaches zero
            if (pick < 80 && ca[14:13] == REGION_IRQ && !ca[0] && $urandom_range(0, 3) != 0)
               cd = DATA_W'($urandom_range(0, 6));
            queue_item(make_item(pick >= 95 ? REQ_VIDEO_TICK : REQ_CPU_WRITE, ca, cd,
                                 PPU_ADDR_W'($urandom)));
            done++;
         end
      end
   endtask

   task automatic csr_write(logic idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (idx == CSR_PRG_BANK_COUNT) m_bank_count = value[BANK_CNT_W-1:0];
      else m_four_screen = value[0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         n_errors++;
      end
   endtask

   // Driver: advance to the next transaction once the current one is taken
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_idle_pct);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_txn.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= pending_txn.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) awaited_rsp.push_back(mapper_step(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               $error("unexpected response transaction %h", rsp_data);
               n_errors++;
            end else begin
               want = awaited_rsp.pop_front();
               check_field("irq_request", want.irq_request, rsp_data.irq_request);
               check_field("mirror_horizontal", want.mirror_horizontal,
                           rsp_data.mirror_horizontal);
               check_field("ram_write_blocked", want.ram_write_blocked,
                           rsp_data.ram_write_blocked);
               check_field("ram_enabled", want.ram_enabled, rsp_data.ram_enabled);
               check_field("prg_bank", want.prg_bank, rsp_data.prg_bank);
               check_field("chr_bank", want.chr_bank, rsp_data.chr_bank);
            end
            n_checked++;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_cartridge_bank_mapper_irq_core: FAIL");
            $finish;
         end
      end
   end

   initial begin
      int bank_counts [SEGMENTS];
      m_bank_count  = PRG_BANK_COUNT_RESET;
      m_four_screen = 1'b0;
      m_bank_sel    = '0;
      m_prg_mode    = 1'b0;
      m_chr_inv     = 1'b0;
      for (int i = 0; i < NUM_BANKS; i++) m_banks[i] = '0;
      m_mirror      = 1'b0;
      m_wprot       = 1'b0;
      m_ram_en      = 1'b0;
      m_latch       = '0;
      m_count       = '0;
      m_irq_on      = 1'b0;
      m_last_a12    = 1'b0;
      m_low_ticks   = '0;
      bank_counts   = '{2, 64, 0, 127, $urandom_range(3, 63), $urandom_range(0, 127)};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         csr_write(CSR_PRG_BANK_COUNT, bank_counts[seg]);
         csr_write(CSR_FOUR_SCREEN, seg % 2);
         send_idle_pct = (seg < 2) ? 33 : (seg < 4) ? 77 : 0;
         recv_idle_pct = (seg < 2) ? 77 : (seg < 4) ? 33 : 0;
         if (seg == 0) begin
            queue_item(make_item(REQ_CPU_WRITE, 16'h0000, 8'hFF, 14'h3FFF));
            queue_item(make_item(REQ_CPU_WRITE, 16'h8000, 8'hC6, 14'h0000));
            queue_item(make_item(REQ_CPU_WRITE, 16'h8001, 8'hFF, 14'h1C00));
            queue_item(make_item(REQ_CPU_WRITE, 16'h9FFE, 8'h07, 14'h1FFF));
            queue_item(make_item(REQ_CPU_WRITE, 16'h9FFF, 8'h80, 14'h0400));
            queue_item(make_item(REQ_CPU_WRITE, 16'hA000, 8'h01, 14'h2000));
            queue_item(make_item(REQ_CPU_WRITE, 16'hBFFF, 8'hC0, 14'h0800));
            // write into work RAM while protected
            queue_item(make_item(REQ_CPU_WRITE, 16'h6000, 8'h00, 14'h1000));
            queue_item(make_item(REQ_CPU_WRITE, 16'hC000, 8'h01, 14'h0C00));
            // reload: next clock reloads from the latch without an interrupt
            queue_item(make_item(REQ_CPU_WRITE, 16'hDFFF, 8'h00, 14'h1400));
            queue_item(make_item(REQ_CPU_WRITE, 16'hE001, 8'h00, 14'h1800));
            queue_scanline(FILTER_TICKS, 1);
            queue_scanline(FILTER_TICKS, 1);
            queue_item(make_item(REQ_CPU_WRITE, 16'hFFFE, 8'h00, 14'h3000));
            queue_item(make_item(REQ_VIDEO_TICK, 16'hFFFF, 8'hFF, 14'h3FFF));
         end
         queue_random(SEGMENT_ITEMS);
         wait (n_checked == n_queued);
      end

      // drain: let any stray response surface
      repeat (8) @(posedge clock);
      if (n_errors == 0) begin
         $display("tb_cartridge_bank_mapper_irq_core: PASS");
      end else begin
         $display("tb_cartridge_bank_mapper_irq_core: FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/cbm_pkg.sv
rtl/core/cbm_regs.sv
rtl/core/cbm_irq.sv
rtl/core/cbm_xlate.sv
rtl/core/cartridge_bank_mapper_irq_core.sv
dv/tb_cartridge_bank_mapper_irq_core.sv
